// ----- sv/block_buffer_cache_lru_defines.svh -----
// ---------------------------------------------------------------------------
// Assertion macros for the buffer cache block
// Checks compile away when SYNTHESIS is defined.
// ---------------------------------------------------------------------------
`ifndef BLOCK_BUFFER_CACHE_LRU_DEFINES_SVH
`define BLOCK_BUFFER_CACHE_LRU_DEFINES_SVH
`ifndef SYNTHESIS
`define BBC_ASSERT_IMP(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("assertion failed");
`define BBC_ASSERT_NXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("assertion failed");
`else
`define BBC_ASSERT_IMP(label, clk, rst_n, ante, cons)
`define BBC_ASSERT_NXT(label, clk, rst_n, ante, cons)
`endif
`endif

// ----- sv/bbc_pkg.sv -----
// ---------------------------------------------------------------------------
// bbc_pkg
// Types, constants and codes shared by the buffer cache modules.
// ---------------------------------------------------------------------------
package bbc_pkg;
    localparam int BufferCount = 16;
    localparam int IdxW  = $clog2(BufferCount);
    localparam int LinkW = $clog2(BufferCount + 1);
    localparam logic [LinkW-1:0] LinkNull = LinkW'(BufferCount);

    typedef enum logic [1:0] {
        OP_GET = 2'd0, OP_READ = 2'd1, OP_WRITE = 2'd2, OP_RELEASE = 2'd3
    } t_opcode;

    typedef enum logic [2:0] {
        ST_HIT = 3'd0, ST_MISS = 3'd1, ST_NO_FREE = 3'd2,
        ST_BUSY = 3'd3, ST_NOT_BUSY = 3'd4
    } t_status;

    typedef struct packed {
        logic [1:0]  opcode;
        logic [14:0] device;
        logic [30:0] block_number;
        logic [3:0]  buffer_index;
    } t_in;

    typedef struct packed {
        logic [3:0] result_buffer;
        logic [2:0] status;
        logic       need_fill;
    } t_out;

    typedef enum logic [2:0] {
        S_IDLE, S_SCAN, S_DECIDE, S_UNLINK, S_APPEND, S_DONE
    } t_state;

    // controller -> datapath
    typedef struct packed {
        logic load;       // capture request, clear scan
        logic scan_step;  // compare one tag, advance
        logic decide;     // pick buffer, set status
        logic unlink;     // take chosen buffer off the free list
        logic append;     // put buffer at tail
        logic out_load;   // load output register
    } t_cmd;

    // datapath -> controller
    typedef struct packed {
        logic scan_done;
        logic do_unlink;
        logic do_append;
    } t_sts;
endpackage

// ----- sv/block_buffer_cache_lru.sv -----
// ---------------------------------------------------------------------------
// block_buffer_cache_lru
// Buffer cache bookkeeping with an LRU free list of idle buffers.
// ---------------------------------------------------------------------------
// Usage:
//  - Input channel i_in_valid/o_in_ready carries one request transaction:
//    get, read, write or release. Output channel o_out_valid/i_out_ready
//    returns exactly one result transaction per request.
//  - Get/read walk the tag store one buffer per cycle, stopping at a hit
//    or after the last of the 16 buffers, then a decide state and at most
//    one list-update state. Write/release skip the scan.
//  - One request is in flight at a time; a new request is taken only
//    after the previous result has been loaded into the output register.
//  - Results sit in an output register; a finished request waits in the
//    done state while the receiver stalls, and no new request is taken.
//  - Reset (synchronous, active low) empties the tags and marks and sets
//    the free list to 0..15 in order; no clearing pass is needed.
//  - An empty free list on a miss returns the no-free status rather
//    than waiting.
// ---------------------------------------------------------------------------
module block_buffer_cache_lru (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_in_valid,
    output logic          o_in_ready,
    input  bbc_pkg::t_in  i_in,
    output logic          o_out_valid,
    input  logic          i_out_ready,
    output bbc_pkg::t_out o_out
);
    import bbc_pkg::*;

    t_cmd w_cmd;
    t_sts w_sts;
    logic w_out_free;

    // sequencer
    bbc_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in_valid),
        .o_in_ready (o_in_ready),
        .i_out_free (w_out_free),
        .i_sts      (w_sts),
        .o_cmd      (w_cmd)
    );

    // tag store, free list, result register
    bbc_datapath u_dp (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in        (i_in),
        .i_cmd       (w_cmd),
        .o_sts       (w_sts),
        .o_out_free  (w_out_free),
        .o_out_valid (o_out_valid),
        .i_out_ready (i_out_ready),
        .o_out       (o_out)
    );
endmodule

// ----- sv/bbc_ctrl.sv -----
// ---------------------------------------------------------------------------
// bbc_ctrl
// Sequencer for lookup, list update and result hand-off.
// ---------------------------------------------------------------------------
`include "block_buffer_cache_lru_defines.svh"
module bbc_ctrl (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_in_valid,
    output logic          o_in_ready,
    input  logic          i_out_free,
    input  bbc_pkg::t_sts i_sts,
    output bbc_pkg::t_cmd o_cmd
);
    import bbc_pkg::*;

    t_state r_state, n_state;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_comb begin
        n_state    = r_state;
        o_cmd      = '0;
        o_in_ready = 1'b0;
        case (r_state)
            S_IDLE: begin
                o_in_ready = 1'b1;
                if (i_in_valid) begin
                    o_cmd.load = 1'b1;
                    n_state    = S_SCAN;
                end
            end
            S_SCAN: begin
                o_cmd.scan_step = 1'b1;
                if (i_sts.scan_done) n_state = S_DECIDE;
            end
            S_DECIDE: begin
                o_cmd.decide = 1'b1;
                if (i_sts.do_unlink)      n_state = S_UNLINK;
                else if (i_sts.do_append) n_state = S_APPEND;
                else                      n_state = S_DONE;
            end
            S_UNLINK: begin
                o_cmd.unlink = 1'b1;
                n_state      = S_DONE;
            end
            S_APPEND: begin
                o_cmd.append = 1'b1;
                n_state      = S_DONE;
            end
            S_DONE: begin
                if (i_out_free) begin
                    o_cmd.out_load = 1'b1;
                    n_state        = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    `BBC_ASSERT_IMP(a_ready_idle, i_clk, i_rst_n, o_in_ready, r_state == S_IDLE)
    `BBC_ASSERT_NXT(a_load_scan, i_clk, i_rst_n, o_cmd.load, r_state == S_SCAN)
    `BBC_ASSERT_IMP(a_out_done, i_clk, i_rst_n, o_cmd.out_load, i_out_free)
endmodule

// ----- sv/bbc_datapath.sv -----
// ---------------------------------------------------------------------------
// bbc_datapath
// Tag store, marks, LRU free list and output register.
// ---------------------------------------------------------------------------
`include "block_buffer_cache_lru_defines.svh"
module bbc_datapath (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  bbc_pkg::t_in  i_in,
    input  bbc_pkg::t_cmd i_cmd,
    output bbc_pkg::t_sts o_sts,
    output logic          o_out_free,
    output logic          o_out_valid,
    input  logic          i_out_ready,
    output bbc_pkg::t_out o_out
);
    import bbc_pkg::*;

    // tags: undefined until written, no reset
    logic [14:0]      r_tdev [BufferCount];
    logic [30:0]      r_tblk [BufferCount];
    logic [BufferCount-1:0] r_tval, r_busy, r_vmark;
    logic [LinkW-1:0] r_next [BufferCount];
    logic [LinkW-1:0] r_prev [BufferCount];
    logic [LinkW-1:0] r_head, r_tail;

    t_in              r_req;
    logic [LinkW-1:0] r_scan;
    logic             r_found;
    logic [IdxW-1:0]  r_hit;
    logic [IdxW-1:0]  r_buf;
    logic [2:0]       r_status;
    logic             r_fill;
    logic             r_out_valid;
    t_out             r_out;

    logic [IdxW-1:0]  w_sidx;
    logic [IdxW-1:0]  w_bidx;
    logic             w_match;
    logic             w_rel_ok;
    logic [LinkW-1:0] w_p, w_n;

    assign w_sidx  = r_scan[IdxW-1:0];
    assign w_bidx  = r_req.buffer_index[IdxW-1:0];
    assign w_match = r_tval[w_sidx] && r_tdev[w_sidx] == r_req.device
                     && r_tblk[w_sidx] == r_req.block_number;
    assign w_rel_ok = ({1'b0, r_req.buffer_index} < LinkW'(BufferCount))
                      && r_busy[w_bidx];
    assign w_p = r_prev[r_buf];
    assign w_n = r_next[r_buf];

    assign o_sts.scan_done = r_req.opcode[1] || r_found
                             || (r_scan == LinkW'(BufferCount - 1)) || w_match;
    assign o_sts.do_unlink = !r_req.opcode[1]
                             && (r_found ? !r_busy[r_hit] : (r_head != LinkNull));
    assign o_sts.do_append = r_req.opcode[1] && w_rel_ok;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_tval      <= '0;
            r_busy      <= '0;
            r_vmark     <= '0;
            r_head      <= '0;
            r_tail      <= LinkW'(BufferCount - 1);
            r_out_valid <= 1'b0;
            for (int i = 0; i < BufferCount; i++) begin
                r_next[i] <= LinkW'(i + 1);
                r_prev[i] <= (i == 0) ? LinkNull : LinkW'(i - 1);
            end
        end else begin
            if (i_cmd.out_load)                r_out_valid <= 1'b1;
            else if (r_out_valid && i_out_ready) r_out_valid <= 1'b0;
            if (i_cmd.load) begin
                r_req   <= i_in;
                r_scan  <= '0;
                r_found <= 1'b0;
            end
            if (i_cmd.scan_step && !r_found && !r_req.opcode[1]) begin
                if (w_match) begin
                    r_found <= 1'b1;
                    r_hit   <= w_sidx;
                end else if (r_scan != LinkW'(BufferCount - 1)) begin
                    r_scan <= r_scan + 1'b1;
                end
            end
            if (i_cmd.decide) begin
                r_fill <= 1'b0;
                if (r_req.opcode[1]) begin
                    r_buf    <= w_bidx;
                    r_status <= w_rel_ok ? ST_HIT : ST_NOT_BUSY;
                    if (w_rel_ok) begin
                        r_busy[w_bidx] <= 1'b0;
                        if (r_req.opcode == OP_WRITE) r_vmark[w_bidx] <= 1'b1;
                    end
                end else if (r_found) begin
                    r_buf <= r_hit;
                    if (r_busy[r_hit]) begin
                        r_status <= ST_BUSY;
                    end else begin
                        r_status      <= ST_HIT;
                        r_busy[r_hit] <= 1'b1;
                        if (r_req.opcode == OP_READ) begin
                            r_fill         <= !r_vmark[r_hit];
                            r_vmark[r_hit] <= 1'b1;
                        end
                    end
                end else if (r_head == LinkNull) begin
                    r_buf    <= '0;
                    r_status <= ST_NO_FREE;
                end else begin
                    r_buf                     <= r_head[IdxW-1:0];
                    r_status                  <= ST_MISS;
                    r_busy[r_head[IdxW-1:0]]  <= 1'b1;
                    r_tval[r_head[IdxW-1:0]]  <= 1'b1;
                    r_tdev[r_head[IdxW-1:0]]  <= r_req.device;
                    r_tblk[r_head[IdxW-1:0]]  <= r_req.block_number;
                    r_vmark[r_head[IdxW-1:0]] <= (r_req.opcode == OP_READ);
                    r_fill                    <= (r_req.opcode == OP_READ);
                end
            end
            if (i_cmd.unlink) begin
                if (w_p != LinkNull) r_next[w_p[IdxW-1:0]] <= w_n;
                else                 r_head <= w_n;
                if (w_n != LinkNull) r_prev[w_n[IdxW-1:0]] <= w_p;
                else                 r_tail <= w_p;
                r_next[r_buf] <= LinkNull;
                r_prev[r_buf] <= LinkNull;
            end
            if (i_cmd.append) begin
                r_prev[r_buf] <= r_tail;
                r_next[r_buf] <= LinkNull;
                if (r_tail != LinkNull) r_next[r_tail[IdxW-1:0]] <= {1'b0, r_buf};
                else                    r_head <= {1'b0, r_buf};
                r_tail <= {1'b0, r_buf};
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.out_load) begin
            r_out.result_buffer <= 4'(r_buf);
            r_out.status        <= r_status;
            r_out.need_fill     <= r_fill;
        end
    end

    assign o_out_free  = !r_out_valid || i_out_ready;
    assign o_out_valid = r_out_valid;
    assign o_out       = r_out;

    `BBC_ASSERT_IMP(a_busy_unlink, i_clk, i_rst_n, i_cmd.unlink, r_busy[r_buf])
    `BBC_ASSERT_IMP(a_append_idle, i_clk, i_rst_n, i_cmd.append, !r_busy[r_buf])
    `BBC_ASSERT_IMP(a_head_idle, i_clk, i_rst_n, r_head != LinkNull,
                    !r_busy[r_head[IdxW-1:0]] || i_cmd.unlink)
endmodule

// ----- test/tb_block_buffer_cache_lru.sv -----
// ---------------------------------------------------------------------------
// Buffer cache bookkeeping testbench
// Drives get, read, write and release transactions with random gaps and
// checks every result against an in-bench model of tags and LRU free list.
// ---------------------------------------------------------------------------
module tb_block_buffer_cache_lru;
    timeunit 1ns;
    timeprecision 1ps;
    import bbc_pkg::*;

    localparam int NB = BufferCount;
    localparam int NIL = NB;

    logic i_clk;
    logic i_rst_n;
    logic i_in_valid;
    logic o_in_ready;
    t_in  i_in;
    logic o_out_valid;
    logic i_out_ready;
    t_out o_out;

    block_buffer_cache_lru dut (
        .i_clk(i_clk), .i_rst_n(i_rst_n),
        .i_in_valid(i_in_valid), .o_in_ready(o_in_ready), .i_in(i_in),
        .o_out_valid(o_out_valid), .i_out_ready(i_out_ready), .o_out(o_out)
    );

    always begin
        i_clk = 1'b1; #6;
        i_clk = 1'b0; #6;
    end

    // Model of the cache bookkeeping
    logic        m_tag_ok [NB];
    logic [14:0] m_dev [NB];
    logic [30:0] m_blk [NB];
    logic        m_busy [NB];
    logic        m_filled [NB];
    int          m_next [NB];
    int          m_prev [NB];
    int          m_head, m_tail;

    t_out expected_results[$];
    int   err_count = 0;
    int   results_seen = 0;
    int   items_sent = 0;
    bit   quiet = 1'b0;     // no idling in the last part of the run
    int   status_hits [5];
    int   stall_left = 0;

    task automatic report_mismatch(input string what, input int got, input int want);
        err_count++;
        $display("%0t mismatch %s: got %0d expected %0d", $time, what, got, want);
    endtask

    function automatic void cache_reset();
        for (int i = 0; i < NB; i++) begin
            m_tag_ok[i] = 1'b0; m_dev[i] = '0; m_blk[i] = '0;
            m_busy[i] = 1'b0; m_filled[i] = 1'b0;
            m_next[i] = (i + 1 < NB) ? i + 1 : NIL;
            m_prev[i] = (i == 0) ? NIL : i - 1;
        end
        m_head = 0;
        m_tail = NB - 1;
    endfunction

    function automatic void list_unlink(input int b);
        int p, n;
        p = m_prev[b];
        n = m_next[b];
        if (p < NB) m_next[p] = n; else m_head = n;
        if (n < NB) m_prev[n] = p; else m_tail = p;
        m_next[b] = NIL;
        m_prev[b] = NIL;
    endfunction

    function automatic void list_append(input int b);
        m_prev[b] = m_tail;
        m_next[b] = NIL;
        if (m_tail < NB) m_next[m_tail] = b; else m_head = b;
        m_tail = b;
    endfunction

    function automatic t_out cache_lookup(input t_in req);
        t_out r;
        int   hit;
        bit   granted;
        r = '0;
        granted = 1'b0;
        if (req.opcode == OP_GET || req.opcode == OP_READ) begin
            hit = -1;
            for (int i = 0; i < NB; i++)
                if (hit < 0 && m_tag_ok[i] && m_dev[i] == req.device
                    && m_blk[i] == req.block_number) hit = i;
            if (hit >= 0) begin
                r.result_buffer = hit[3:0];
                if (m_busy[hit]) begin
                    r.status = ST_BUSY;
                end else begin
                    list_unlink(hit);
                    m_busy[hit] = 1'b1;
                    r.status = ST_HIT;
                    granted = 1'b1;
                end
            end else if (m_head >= NB) begin
                r.status = ST_NO_FREE;
            end else begin
                hit = m_head;
                list_unlink(hit);
                m_busy[hit] = 1'b1;
                m_filled[hit] = 1'b0;
                m_tag_ok[hit] = 1'b1;
                m_dev[hit] = req.device;
                m_blk[hit] = req.block_number;
                r.result_buffer = hit[3:0];
                r.status = ST_MISS;
                granted = 1'b1;
            end
            if (req.opcode == OP_READ && granted) begin
                r.need_fill = !m_filled[hit];
                m_filled[hit] = 1'b1;
            end
        end else begin
            r.result_buffer = req.buffer_index;
            if (!m_busy[req.buffer_index]) begin
                r.status = ST_NOT_BUSY;
            end else begin
                if (req.opcode == OP_WRITE) m_filled[req.buffer_index] = 1'b1;
                m_busy[req.buffer_index] = 1'b0;
                list_append(req.buffer_index);
                r.status = ST_HIT;
            end
        end
        return r;
    endfunction

    // Send one transaction; the expectation is queued at acceptance.
    // Valid stays high after acceptance until the next call drives it.
    task automatic send_request(input t_in req);
        if (!quiet && $urandom_range(0, 3) == 0) begin
            i_in_valid <= 1'b0;
            repeat ($urandom_range(1, 4)) @(posedge i_clk);
        end
        i_in_valid <= 1'b1;
        i_in <= req;
        do @(posedge i_clk); while (!o_in_ready);
        expected_results.push_back(cache_lookup(req));
        items_sent++;
    endtask

    function automatic t_in make_req(input t_opcode op, input logic [14:0] dev,
                                     input logic [30:0] blk, input logic [3:0] idx);
        t_in r;
        r.opcode = op;
        r.device = dev;
        r.block_number = blk;
        r.buffer_index = idx;
        return r;
    endfunction

    // Small key pool so hits and collisions are frequent
    function automatic t_in random_request();
        t_opcode op;
        logic [14:0] dev;
        logic [30:0] blk;
        op = t_opcode'($urandom_range(0, 3));
        if ($urandom_range(0, 9) < 8) begin
            dev = 15'($urandom_range(0, 3)) ^ (($urandom_range(0, 7) == 0) ? 15'h7FFC : 15'h0);
            blk = 31'($urandom_range(0, 9));
            if ($urandom_range(0, 5) == 0) blk = blk | 31'h7FFFFFF0;
        end else begin
            dev = 15'($urandom);
            blk = 31'($urandom);
        end
        return make_req(op, dev, blk, 4'($urandom_range(0, 15)));
    endfunction

    // Result checker
    always @(posedge i_clk) begin
        if (i_rst_n && o_out_valid && i_out_ready) begin
            if (expected_results.size() == 0) begin
                report_mismatch("unexpected transaction", 1, 0);
            end else begin
                t_out want;
                want = expected_results.pop_front();
                results_seen++;
                if (want.status < 5) status_hits[want.status]++;
                if (o_out.result_buffer !== want.result_buffer)
                    report_mismatch("result_buffer", o_out.result_buffer, want.result_buffer);
                if (o_out.status !== want.status)
                    report_mismatch("status", o_out.status, want.status);
                if (o_out.need_fill !== want.need_fill)
                    report_mismatch("need_fill", o_out.need_fill, want.need_fill);
            end
        end
    end

    // Receiver stalls at random, holding ready low in bursts
    always @(posedge i_clk) begin
        if (!i_rst_n || quiet) begin
            i_out_ready <= 1'b1;
            stall_left = 0;
        end else if (stall_left > 0) begin
            stall_left--;
            i_out_ready <= (stall_left == 0);
        end else if ($urandom_range(0, 4) == 0) begin
            stall_left = $urandom_range(1, 4);
            i_out_ready <= 1'b0;
        end else begin
            i_out_ready <= 1'b1;
        end
    end

    task automatic test_field_extremes();
        send_request(make_req(OP_READ, 15'h7FFF, 31'h7FFFFFFF, 4'h0));
        send_request(make_req(OP_READ, 15'h7FFF, 31'h7FFFFFFF, 4'hF));
        send_request(make_req(OP_GET, 15'h0, 31'h0, 4'h0));
        send_request(make_req(OP_RELEASE, 15'h0, 31'h0, 4'h0));
        send_request(make_req(OP_GET, 15'h7FFF, 31'h7FFFFFFF, 4'h0));
        send_request(make_req(OP_WRITE, 15'h0, 31'h0, 4'h1));
        send_request(make_req(OP_READ, 15'h0, 31'h0, 4'h0));
        send_request(make_req(OP_RELEASE, 15'h0, 31'h0, 4'h0));
        send_request(make_req(OP_RELEASE, 15'h0, 31'h0, 4'hF));
        send_request(make_req(OP_WRITE, 15'h0, 31'h0, 4'hF));
    endtask

    // Exhaust the free list, then release everything
    task automatic test_empty_free_list();
        for (int i = 0; i < NB; i++)
            send_request(make_req(OP_GET, 15'd100, 31'(i), 4'h0));
        send_request(make_req(OP_READ, 15'd101, 31'd0, 4'h0));
        for (int i = 0; i < NB; i++)
            send_request(make_req((i % 2) ? OP_WRITE : OP_RELEASE, 15'h0, 31'h0, 4'(i)));
    endtask

    task automatic test_random_traffic(input int count);
        for (int n = 0; n < count; n++) begin
            if (n == count - 150) quiet = 1'b1;
            send_request(random_request());
        end
    endtask

    initial begin
        i_rst_n = 1'b0;
        i_in_valid = 1'b0;
        i_in = '0;
        i_out_ready = 1'b1;
        cache_reset();
        repeat (5) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);
        test_field_extremes();
        test_empty_free_list();
        test_random_traffic(1400);
        i_in_valid <= 1'b0;
        while (expected_results.size() != 0) @(posedge i_clk);
        repeat (30) @(posedge i_clk);
        $display("%0d transactions sent, %0d results checked", items_sent, results_seen);
        $display("status counts hit/miss/nofree/busy/notbusy: %0d %0d %0d %0d %0d",
                 status_hits[0], status_hits[1], status_hits[2], status_hits[3],
                 status_hits[4]);
        if (err_count == 0) begin
            $display("tb_block_buffer_cache_lru: PASS");
        end else begin
            $display("tb_block_buffer_cache_lru: FAIL");
        end
        $finish;
    end

    initial begin
        #2ms;
        $display("timeout");
        $display("tb_block_buffer_cache_lru: FAIL");
        $finish;
    end
endmodule
